>>> hdl/tnc_pkg.sv
`timescale 1ns / 1ps
package tnc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int NUM_COMP      = 6;
  localparam int COMP_W        = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 2;

  // component slots of a vertex row
  localparam logic [COMP_W-1:0] COMP_X = 3'd0;
  localparam logic [COMP_W-1:0] COMP_Y = 3'd1;
  localparam logic [COMP_W-1:0] COMP_Z = 3'd2;
  localparam logic [COMP_W-1:0] COMP_W_SLOT = 3'd3;
  localparam logic [COMP_W-1:0] COMP_VA = 3'd4;
  localparam logic [COMP_W-1:0] COMP_VB = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CULL_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE = 1'b1;

  localparam logic [1:0] CULL_NONE  = 2'd0;
  localparam logic [1:0] CULL_BACK  = 2'd1;
  localparam logic [1:0] CULL_FRONT = 2'd2;

  localparam logic FILL_SOLID = 1'b0;
  localparam logic FILL_WIRE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_COPY,
    OP_CLIP_DIV,
    OP_BLEND_MUL,
    OP_BLEND_ADD,
    OP_PROJ_DIV,
    OP_PROJ_STORE,
    OP_CROSS_MUL,
    OP_CROSS_ACC,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [1:0]        ia;
    logic [1:0]        ib;
    logic [1:0]        dst;
    logic [COMP_W-1:0] comp;
    logic [1:0]        step;
    logic              last;
    logic              in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       out_free;
    logic [2:0] z_neg;
    logic       div_done;
    logic       cross_neg;
    logic       cross_zero;
  } dp_sts_t;

  // polygon vertex for each emitted position
  function automatic logic [1:0] emit_vtx(input logic fill, input logic quad,
                                          input logic [2:0] step);
    logic [15:0] seq;
    unique case ({fill, quad})
      2'b00: seq = 16'b00_00_00_00_00_10_01_00;
      2'b01: seq = 16'b00_00_11_10_00_10_01_00;
      2'b10: seq = 16'b00_00_00_10_10_01_01_00;
      2'b11: seq = 16'b00_11_11_10_10_01_01_00;
    endcase
    return seq[{step, 1'b0} +: 2];
  endfunction

  function automatic logic [3:0] emit_count(input logic fill, input logic quad);
    logic [3:0] n;
    unique case ({fill, quad})
      2'b00: n = 4'd3;
      2'b01: n = 4'd6;
      2'b10: n = 4'd6;
      2'b11: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/tnc_if.sv
`timescale 1ns / 1ps
interface tnc_in_if;
  import tnc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;
  logic signed [COORD_W-1:0]  pos_w;
  logic signed [COORD_W-1:0]  vary_a;
  logic signed [COORD_W-1:0]  vary_b;

  modport source (output valid, pos_x, pos_y, pos_z, pos_w, vary_a, vary_b,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, pos_w, vary_a, vary_b,
                output ready);
endinterface

interface tnc_out_if;
  import tnc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic signed [COORD_W-1:0]  out_z;
  logic signed [COORD_W-1:0]  out_w;
  logic signed [COORD_W-1:0]  out_vary_a;
  logic signed [COORD_W-1:0]  out_vary_b;
  logic                       run_end;

  modport source (output valid, out_x, out_y, out_z, out_w, out_vary_a, out_vary_b,
                  run_end, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, out_vary_a, out_vary_b,
                run_end, output ready);
endinterface

>>> hdl/tnc_div.sv
`timescale 1ns / 1ps
module tnc_div #(
  parameter int DIV_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [32:0]      divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [32:0]      rem_q;
  logic [32:0]      dvs_q;
  logic [DIV_W-1:0] quot_q;
  logic [33:0]      rem_sh;
  logic [33:0]      rem_nx;
  logic             fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_q, quot_q[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], fits};
      rem_q  <= rem_nx[32:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> hdl/tnc_ctrl.sv
`timescale 1ns / 1ps
module tnc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  tnc_pkg::dp_sts_t               sts_i,
  output tnc_pkg::dp_cmd_t               cmd_o
);
  import tnc_pkg::*;

  typedef enum logic [12:0] {
    S_GATHER = 13'b0000000000001,
    S_EDGE   = 13'b0000000000010,
    S_CDIV   = 13'b0000000000100,
    S_CWAIT  = 13'b0000000001000,
    S_BMUL   = 13'b0000000010000,
    S_BADD   = 13'b0000000100000,
    S_DECIDE = 13'b0000001000000,
    S_PDIV   = 13'b0000010000000,
    S_PWAIT  = 13'b0000100000000,
    S_XMUL   = 13'b0001000000000,
    S_XACC   = 13'b0010000000000,
    S_XDEC   = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [1:0]        edge_q, edge_d;
  logic [2:0]        n_q, n_d;
  logic [1:0]        ca_q, ca_d;
  logic [1:0]        cb_q, cb_d;
  logic [COMP_W-1:0] comp_q, comp_d;
  logic [1:0]        pv_q, pv_d;
  logic              pax_q, pax_d;
  logic [1:0]        xs_q, xs_d;
  logic [2:0]        es_q, es_d;
  logic [1:0]        cull_q;
  logic              fill_q;

  logic [1:0]        edge_nx;
  logic              zi_neg, zj_neg, adv_edge, quad, last, keep, cross_pos;
  logic [3:0]        emit_len;

  always_comb begin
    edge_nx   = (edge_q == 2'd2) ? 2'd0 : 2'(edge_q + 2'd1);
    zi_neg    = sts_i.z_neg[edge_q];
    zj_neg    = sts_i.z_neg[edge_nx];
    quad      = (n_q == 3'd4);
    emit_len  = emit_count(fill_q, quad);
    last      = ({1'b0, es_q} == 4'(emit_len - 4'd1));
    cross_pos = !sts_i.cross_neg && !sts_i.cross_zero;
    keep      = (cull_q == CULL_BACK) ? !cross_pos : cross_pos;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    edge_d   = edge_q;
    n_d      = n_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    comp_d   = comp_q;
    pv_d     = pv_q;
    pax_d    = pax_q;
    xs_d     = xs_q;
    es_d     = es_q;
    adv_edge = 1'b0;
    cmd_o    = '{op: OP_NONE, ia: ca_q, ib: cb_q, dst: n_q[1:0], comp: comp_q,
                 step: xs_q, last: 1'b0, in_ready: 1'b0};

    unique case (state_q)
      S_GATHER: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.dst      = cnt_q;
        if (sts_i.in_valid) begin
          cmd_o.op = OP_LOAD;
          if (cnt_q == 2'd2) begin
            cnt_d   = 2'd0;
            n_d     = 3'd0;
            edge_d  = 2'd0;
            state_d = S_EDGE;
          end else begin
            cnt_d = 2'(cnt_q + 2'd1);
          end
        end
      end
      S_EDGE: begin
        cmd_o.ia = edge_q;
        if (!zi_neg) begin
          cmd_o.op = OP_COPY;
          n_d      = 3'(n_q + 3'd1);
        end
        if (!zi_neg && zj_neg) begin
          ca_d    = edge_q;
          cb_d    = edge_nx;
          state_d = S_CDIV;
        end else if (zi_neg && !zj_neg) begin
          ca_d    = edge_nx;
          cb_d    = edge_q;
          state_d = S_CDIV;
        end else begin
          adv_edge = 1'b1;
        end
      end
      S_CDIV: begin
        cmd_o.op = OP_CLIP_DIV;
        state_d  = S_CWAIT;
      end
      S_CWAIT: begin
        if (sts_i.div_done) begin
          comp_d  = COMP_X;
          state_d = S_BMUL;
        end
      end
      S_BMUL: begin
        cmd_o.op = OP_BLEND_MUL;
        state_d  = S_BADD;
      end
      S_BADD: begin
        cmd_o.op = OP_BLEND_ADD;
        if (comp_q == COMP_VB) begin
          n_d      = 3'(n_q + 3'd1);
          adv_edge = 1'b1;
        end else begin
          comp_d  = 3'(comp_q + 3'd1);
          state_d = S_BMUL;
        end
      end
      S_DECIDE: begin
        if (n_q < 3'd3) begin
          state_d = S_GATHER;
        end else if (cull_q == CULL_BACK || cull_q == CULL_FRONT) begin
          pv_d    = 2'd0;
          pax_d   = 1'b0;
          state_d = S_PDIV;
        end else begin
          es_d    = 3'd0;
          state_d = S_EMIT;
        end
      end
      S_PDIV: begin
        cmd_o.op   = OP_PROJ_DIV;
        cmd_o.ia   = pv_q;
        cmd_o.comp = pax_q ? COMP_Y : COMP_X;
        state_d    = S_PWAIT;
      end
      S_PWAIT: begin
        cmd_o.ia   = pv_q;
        cmd_o.comp = pax_q ? COMP_Y : COMP_X;
        if (sts_i.div_done) begin
          cmd_o.op = OP_PROJ_STORE;
          if (pax_q) begin
            pax_d = 1'b0;
            if (pv_q == 2'd2) begin
              xs_d    = 2'd0;
              state_d = S_XMUL;
            end else begin
              pv_d    = 2'(pv_q + 2'd1);
              state_d = S_PDIV;
            end
          end else begin
            pax_d   = 1'b1;
            state_d = S_PDIV;
          end
        end
      end
      S_XMUL: begin
        cmd_o.op = OP_CROSS_MUL;
        state_d  = S_XACC;
      end
      S_XACC: begin
        cmd_o.op = OP_CROSS_ACC;
        if (xs_q == 2'd3) begin
          state_d = S_XDEC;
        end else begin
          xs_d    = 2'(xs_q + 2'd1);
          state_d = S_XMUL;
        end
      end
      S_XDEC: begin
        es_d    = 3'd0;
        state_d = keep ? S_EMIT : S_GATHER;
      end
      S_EMIT: begin
        cmd_o.ia   = emit_vtx(fill_q, quad, es_q);
        cmd_o.last = last;
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          es_d     = 3'(es_q + 3'd1);
          if (last) state_d = S_GATHER;
        end
      end
      default: state_d = S_GATHER;
    endcase

    if (adv_edge) begin
      if (edge_q == 2'd2) begin
        state_d = S_DECIDE;
      end else begin
        edge_d  = edge_nx;
        state_d = S_EDGE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_GATHER;
      cnt_q   <= '0;
      edge_q  <= '0;
      n_q     <= '0;
      ca_q    <= '0;
      cb_q    <= '0;
      comp_q  <= '0;
      pv_q    <= '0;
      pax_q   <= 1'b0;
      xs_q    <= '0;
      es_q    <= '0;
      cull_q  <= CULL_NONE;
      fill_q  <= FILL_SOLID;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      edge_q  <= edge_d;
      n_q     <= n_d;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      comp_q  <= comp_d;
      pv_q    <= pv_d;
      pax_q   <= pax_d;
      xs_q    <= xs_d;
      es_q    <= es_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CULL_MODE: cull_q <= cfg_data_i;
          CFG_FILL_MODE: fill_q <= cfg_data_i[0];
        endcase
      end
    end
  end
endmodule

>>> hdl/tnc_dp.sv
`timescale 1ns / 1ps
module tnc_dp #(
  parameter int FRAC_BITS = tnc_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tnc_in_if.sink           in_i,
  tnc_out_if.source        out_o,
  input  tnc_pkg::dp_cmd_t cmd_i,
  output tnc_pkg::dp_sts_t sts_o
);
  import tnc_pkg::*;

  localparam int DIV_W   = COORD_W + FRAC_BITS;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MUL_B_W = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int PROD_W  = DIFF_W + MUL_B_W;
  localparam int SPLIT   = 17;
  localparam int ACC_W   = 2 * DIFF_W + 1;

  logic signed [COORD_W-1:0] corner_q [3][NUM_COMP];
  logic signed [COORD_W-1:0] poly_q   [4][NUM_COMP];
  logic signed [COORD_W-1:0] px_q [3];
  logic signed [COORD_W-1:0] py_q [3];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      pneg_q, pzero_q;
  logic                      ovalid_q;

  logic signed [COORD_W-1:0] ca, cb, za, zb, pv, pw, proj, vmag_s, wmag_s;
  logic        [COORD_W-1:0] vmag, wmag;
  logic signed [DIFF_W-1:0]  mul_a, cr_a, cr_b, cr_c, cr_d;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc_ext, acc_sh, acc_term, acc_base;
  logic        [FRAC_BITS:0] clip_f;
  logic                      div_start, div_done, neg_over, pos_over;
  logic        [DIV_W-1:0]   div_dvd, div_quot;
  logic        [DIFF_W-1:0]  div_dvs;

  tnc_div #(.DIV_W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    ca     = corner_q[cmd_i.ia][cmd_i.comp];
    cb     = corner_q[cmd_i.ib][cmd_i.comp];
    za     = corner_q[cmd_i.ia][COMP_Z];
    zb     = corner_q[cmd_i.ib][COMP_Z];
    pv     = poly_q[cmd_i.ia][cmd_i.comp];
    pw     = poly_q[cmd_i.ia][COMP_W_SLOT];
    vmag_s = pv[COORD_W-1] ? -pv : pv;
    wmag_s = pw[COORD_W-1] ? -pw : pw;
    vmag   = vmag_s;
    wmag   = wmag_s;
    clip_f = div_quot[FRAC_BITS:0];

    div_start = (cmd_i.op == OP_CLIP_DIV) || (cmd_i.op == OP_PROJ_DIV);
    if (cmd_i.op == OP_CLIP_DIV) begin
      div_dvd = {za, {FRAC_BITS{1'b0}}};
      div_dvs = DIFF_W'(za) - DIFF_W'(zb);
    end else begin
      div_dvd = {vmag, {FRAC_BITS{1'b0}}};
      div_dvs = {1'b0, wmag};
    end

    // edge vectors of the projected triangle
    cr_a = DIFF_W'(px_q[2]) - DIFF_W'(px_q[0]);
    cr_b = DIFF_W'(py_q[2]) - DIFF_W'(py_q[1]);
    cr_c = DIFF_W'(py_q[2]) - DIFF_W'(py_q[0]);
    cr_d = DIFF_W'(px_q[2]) - DIFF_W'(px_q[1]);

    // shared multiplier: blend slope or a split cross partial product
    // low halves are unsigned, high halves carry the sign
    if (cmd_i.op == OP_BLEND_MUL) begin
      mul_a = DIFF_W'(cb) - DIFF_W'(ca);
      mul_b = MUL_B_W'(clip_f);
    end else begin
      unique case (cmd_i.step)
        2'd0: begin mul_a = cr_a; mul_b = MUL_B_W'(cr_b[SPLIT-1:0]); end
        2'd1: begin mul_a = cr_a; mul_b = MUL_B_W'($signed(cr_b[DIFF_W-1:SPLIT])); end
        2'd2: begin mul_a = cr_c; mul_b = MUL_B_W'(cr_d[SPLIT-1:0]); end
        2'd3: begin mul_a = cr_c; mul_b = MUL_B_W'($signed(cr_d[DIFF_W-1:SPLIT])); end
      endcase
    end
    prod = mul_a * mul_b;

    acc_ext  = ACC_W'(prod_q);
    acc_sh   = cmd_i.step[0] ? (acc_ext <<< SPLIT) : acc_ext;
    acc_term = cmd_i.step[1] ? -acc_sh : acc_sh;
    acc_base = (cmd_i.step == 2'd0) ? '0 : acc_q;

    // saturate the projected magnitude back to 32 bits
    pos_over = |div_quot[DIV_W-1:COORD_W-1];
    neg_over = (|div_quot[DIV_W-1:COORD_W]) ||
               (div_quot[COORD_W-1] && |div_quot[COORD_W-2:0]);
    if (pzero_q) begin
      proj = '0;
    end else if (pneg_q) begin
      proj = neg_over ? {1'b1, {(COORD_W-1){1'b0}}} : -div_quot[COORD_W-1:0];
    end else begin
      proj = pos_over ? {1'b0, {(COORD_W-1){1'b1}}} : div_quot[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        corner_q[cmd_i.dst][COMP_X]      <= in_i.pos_x;
        corner_q[cmd_i.dst][COMP_Y]      <= in_i.pos_y;
        corner_q[cmd_i.dst][COMP_Z]      <= in_i.pos_z;
        corner_q[cmd_i.dst][COMP_W_SLOT] <= in_i.pos_w;
        corner_q[cmd_i.dst][COMP_VA]     <= in_i.vary_a;
        corner_q[cmd_i.dst][COMP_VB]     <= in_i.vary_b;
      end
      OP_COPY:      poly_q[cmd_i.dst] <= corner_q[cmd_i.ia];
      OP_BLEND_MUL: prod_q <= prod;
      OP_BLEND_ADD: poly_q[cmd_i.dst][cmd_i.comp] <=
                      ca + COORD_W'(prod_q >>> FRAC_BITS);
      OP_PROJ_DIV: begin
        pneg_q  <= pv[COORD_W-1] ^ pw[COORD_W-1];
        pzero_q <= (pv == '0);
      end
      OP_PROJ_STORE: begin
        if (cmd_i.comp == COMP_Y) py_q[cmd_i.ia] <= proj;
        else                      px_q[cmd_i.ia] <= proj;
      end
      OP_CROSS_MUL: prod_q <= prod;
      OP_CROSS_ACC: acc_q <= acc_base + acc_term;
      OP_EMIT: begin
        out_o.out_x      <= poly_q[cmd_i.ia][COMP_X];
        out_o.out_y      <= poly_q[cmd_i.ia][COMP_Y];
        out_o.out_z      <= poly_q[cmd_i.ia][COMP_Z];
        out_o.out_w      <= poly_q[cmd_i.ia][COMP_W_SLOT];
        out_o.out_vary_a <= poly_q[cmd_i.ia][COMP_VA];
        out_o.out_vary_b <= poly_q[cmd_i.ia][COMP_VB];
        out_o.run_end    <= cmd_i.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  assign out_o.valid = ovalid_q;
  assign in_i.ready  = cmd_i.in_ready;

  always_comb begin
    sts_o.in_valid   = in_i.valid;
    sts_o.out_free   = !ovalid_q || out_o.ready;
    sts_o.z_neg      = {corner_q[2][COMP_Z][COORD_W-1], corner_q[1][COMP_Z][COORD_W-1],
                        corner_q[0][COMP_Z][COORD_W-1]};
    sts_o.div_done   = div_done;
    sts_o.cross_neg  = acc_q[ACC_W-1];
    sts_o.cross_zero = (acc_q == '0);
  end
endmodule

>>> hdl/triangle_near_clip_and_cull_top.sv
`timescale 1ns / 1ps
// the first two vertices of a triangle are each loaded on arrival; the third starts a run over
// each edge, with a divide and a blend of every component for a clipped edge, then a decision,
// projection divides and the cross product when culling is on, then one vertex out per cycle
// while the output is free (up to 8); the shared divider is radix-2, one bit per cycle
// reset: rst_ni is asynchronous and active low, clears the sequencer, the vertex
// count, the output valid and both mode registers; vertex storage is not cleared
module triangle_near_clip_and_cull_top #(
  parameter int FRAC_BITS = tnc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tnc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tnc_in_if.sink                         in_i,
  tnc_out_if.source                      out_o
);
  import tnc_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: gathers vertices, walks each edge of the triangle, runs projection,
  // cross product and the emit table; holds cull and fill mode
  tnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: corner and polygon storage, shared multiplier, shared divider,
  // cross accumulator and the output register of the result channel
  tnc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );
endmodule

>>> hdl/tnc_checker.sv
`timescale 1ns / 1ps
module tnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_i,
  input logic        out_run_end_i
);
  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_run_end_i))
    else $error("output changed while stalled");

  // no new vertex is taken while a triangle is still being emitted
  a_no_in_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_run_end_i |-> !in_ready_i)
    else $error("input ready in the middle of an emitted run");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");
endmodule

bind triangle_near_clip_and_cull_top tnc_checker u_tnc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_x_i       (out_o.out_x),
  .out_run_end_i (out_o.run_end)
);
